>>> hdl/goal_distance_turn_time_estimate_unit_assert.svh
`ifndef GOAL_DISTANCE_TURN_TIME_ESTIMATE_UNIT_ASSERT_SVH
`define GOAL_DISTANCE_TURN_TIME_ESTIMATE_UNIT_ASSERT_SVH

// same-cycle implication on clk, off while arst_n is low
`define GDTE_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication on clk, off while arst_n is low
`define GDTE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/gdte_pkg.sv
package gdte_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int IDX_W = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;

	localparam int POS_W = 32;
	localparam int HD_W  = 16;
	localparam int CFG_W = 24;
	localparam int GUARD = 8;

	// difference vector with guard bits, plus headroom for the CORDIC gain
	localparam int XW     = 44;
	// angle in units of 2^-29 rad
	localparam int ZW     = 34;
	localparam int ERR_W  = 31;
	localparam int RNG_W  = 34;

	localparam logic signed [ZW-1:0] ANG_PI     = 34'sd1686629713;
	localparam logic signed [ZW-1:0] ANG_TWO_PI = 34'sd3373259426;
	localparam logic [31:0]          INV_GAIN   = 32'd2608131497;

	localparam logic [CFG_W-1:0] SPM_RESET = 24'd32768;
	localparam logic [CFG_W-1:0] SPR_RESET = 24'd65536;

	localparam int CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SECS_PER_METRE  = 2'd0,
		REG_SECS_PER_RADIAN = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
	} cordic_t;

	typedef struct packed {
		logic signed [POS_W-1:0] goal_x;
		logic signed [POS_W-1:0] goal_y;
		logic signed [HD_W-1:0]  heading;
	} pass_t;

	function automatic logic signed [ZW-1:0] atan_entry(input logic [IDX_W-1:0] i);
		logic signed [ZW-1:0] r;
		case (int'(i))
			0: r = 34'sd421657428;
			1: r = 34'sd248918915;
			2: r = 34'sd131521918;
			3: r = 34'sd66762579;
			4: r = 34'sd33510843;
			5: r = 34'sd16771758;
			6: r = 34'sd8387925;
			7: r = 34'sd4194219;
			8: r = 34'sd2097141;
			9: r = 34'sd1048575;
			default: r = (int'(i) <= 29) ? (ZW'(1) << (29 - int'(i))) : '0;
		endcase
		return r;
	endfunction

endpackage

>>> hdl/gdte_cordic_stage.sv
module gdte_cordic_stage
	import gdte_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] idx,
	input  logic             in_valid,
	output logic             in_ready,
	input  cordic_t          in_vec,
	input  pass_t            in_pass,
	output logic             out_valid,
	input  logic             out_ready,
	output cordic_t          out_vec,
	output pass_t            out_pass
);

	logic    vld_s1;
	cordic_t vec_s1;
	pass_t   pass_s1;
	cordic_t nxt;
	logic signed [XW-1:0] xs, ys;
	logic signed [ZW-1:0] ang;
	logic    ld;

	assign ld = !vld_s1 || out_ready;
	assign in_ready = ld;

	// idx is tied to a constant per instance, so the shifts fold to wiring
	always_comb begin
		xs  = in_vec.x >>> idx;
		ys  = in_vec.y >>> idx;
		ang = atan_entry(idx);
		if (in_vec.y[XW-1]) begin
			nxt.x = in_vec.x - ys;
			nxt.y = in_vec.y + xs;
			nxt.z = in_vec.z - ang;
		end else begin
			nxt.x = in_vec.x + ys;
			nxt.y = in_vec.y - xs;
			nxt.z = in_vec.z + ang;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (ld) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ld && in_valid) begin
			vec_s1  <= nxt;
			pass_s1 <= in_pass;
		end
	end

	assign out_valid = vld_s1;
	assign out_vec   = vec_s1;
	assign out_pass  = pass_s1;

endmodule

>>> hdl/gdte_post.sv
module gdte_post
	import gdte_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [CFG_W-1:0]  secs_per_metre,
	input  logic [CFG_W-1:0]  secs_per_radian,
	input  logic              in_valid,
	output logic              in_ready,
	input  cordic_t           in_vec,
	input  pass_t             in_pass,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [31:0]       range_to_goal,
	output logic [31:0]       travel_secs,
	output pass_t             out_pass
);

	localparam int UX_W = XW - 1;
	localparam int XH_W = UX_W - 32;
	localparam int PH_W = UX_W;
	localparam int PL_W = 64;
	localparam int SC_W = PH_W + 1;
	localparam int RF_W = SC_W + 1 - GUARD;
	localparam int DP_W = RNG_W + CFG_W;
	localparam int TP_W = ERR_W + CFG_W;
	localparam int DR_W = DP_W + 1 - 16;
	localparam int TR_W = TP_W + 1 - 29;
	localparam int TT_W = ((DR_W > TR_W) ? DR_W : TR_W) + 1;

	logic v_s1, v_s2, v_s3, v_s4;
	logic ld1, ld2, ld3, ld4;

	// s1: gain products, raw bearing error
	logic [PH_W-1:0]      ph_s1;
	logic [PL_W-1:0]      pl_s1;
	logic signed [ZW-1:0] e_s1;
	pass_t                pass_s1;
	logic [UX_W-1:0]      ux;
	logic [XH_W-1:0]      xh;
	logic signed [ZW-1:0] e_c;

	// s2: range, wrapped |error|
	logic [RNG_W-1:0] range_s2;
	logic [ERR_W-1:0] err_s2;
	pass_t            pass_s2;
	logic [32:0]          rnd_c;
	logic [SC_W-1:0]      scaled_c;
	logic [RF_W-1:0]      rfull_c;
	logic signed [ZW-1:0] ew_c, ea_c;

	// s3: time products
	logic [DP_W-1:0] dprod_s3;
	logic [TP_W-1:0] tprod_s3;
	logic [31:0]     rsat_s3;
	pass_t           pass_s3;

	// s4: output register
	logic [31:0] rsat_s4;
	logic [31:0] tsat_s4;
	pass_t       pass_s4;
	logic [DR_W-1:0] drive_c;
	logic [TR_W-1:0] turn_c;
	logic [TT_W-1:0] total_c;

	assign ld4 = !v_s4 || out_ready;
	assign ld3 = !v_s3 || ld4;
	assign ld2 = !v_s2 || ld3;
	assign ld1 = !v_s1 || ld2;
	assign in_ready = ld1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (ld1) v_s1 <= in_valid;
			if (ld2) v_s2 <= v_s1;
			if (ld3) v_s3 <= v_s2;
			if (ld4) v_s4 <= v_s3;
		end
	end

	always_comb begin
		ux  = in_vec.x[XW-1] ? '0 : in_vec.x[UX_W-1:0];
		xh  = ux[UX_W-1:32];
		e_c = in_vec.z - (ZW'(in_pass.heading) <<< 16);
	end

	always_ff @(posedge clk) begin
		if (ld1 && in_valid) begin
			ph_s1   <= PH_W'(xh) * PH_W'(INV_GAIN);
			pl_s1   <= PL_W'(ux[31:0]) * PL_W'(INV_GAIN);
			e_s1    <= e_c;
			pass_s1 <= in_pass;
		end
	end

	always_comb begin
		rnd_c    = 33'((65'(pl_s1) + 65'(33'h080000000)) >> 32);
		scaled_c = SC_W'(ph_s1) + SC_W'(rnd_c);
		rfull_c  = RF_W'((SC_W'(scaled_c) + SC_W'(1 << (GUARD - 1))) >> GUARD);
		if (e_s1 > ANG_PI) begin
			ew_c = e_s1 - ANG_TWO_PI;
		end else if (e_s1 < -ANG_PI) begin
			ew_c = e_s1 + ANG_TWO_PI;
		end else begin
			ew_c = e_s1;
		end
		ea_c = ew_c[ZW-1] ? -ew_c : ew_c;
	end

	always_ff @(posedge clk) begin
		if (ld2 && v_s1) begin
			range_s2 <= rfull_c[RNG_W-1:0];
			err_s2   <= ea_c[ERR_W-1:0];
			pass_s2  <= pass_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ld3 && v_s2) begin
			dprod_s3 <= DP_W'(range_s2) * DP_W'(secs_per_metre);
			tprod_s3 <= TP_W'(err_s2) * TP_W'(secs_per_radian);
			rsat_s3  <= (|range_s2[RNG_W-1:32]) ? 32'hFFFF_FFFF : range_s2[31:0];
			pass_s3  <= pass_s2;
		end
	end

	always_comb begin
		drive_c = DR_W'(((DP_W + 1)'(dprod_s3) + (DP_W + 1)'(1 << 15)) >> 16);
		turn_c  = TR_W'(((TP_W + 1)'(tprod_s3) + (TP_W + 1)'(1 << 28)) >> 29);
		total_c = TT_W'(drive_c) + TT_W'(turn_c);
	end

	always_ff @(posedge clk) begin
		if (ld4 && v_s3) begin
			rsat_s4 <= rsat_s3;
			tsat_s4 <= (|total_c[TT_W-1:32]) ? 32'hFFFF_FFFF : total_c[31:0];
			pass_s4 <= pass_s3;
		end
	end

	assign out_valid     = v_s4;
	assign range_to_goal = rsat_s4;
	assign travel_secs   = tsat_s4;
	assign out_pass      = pass_s4;

endmodule

>>> hdl/goal_distance_turn_time_estimate_unit.sv
// Beats pass the front register, then the CORDIC stage chain, then post stages s1 to s4.
// Throughput: one beat per cycle while out_ready holds; every stage holds its own valid bit and
// bubbles close up under output backpressure.
// Rate is set by the unrolled CORDIC chain, one micro-rotation per stage.
// Reset (arst_n low, async) empties every stage; secs_per_metre resets to 0.5,
// secs_per_radian to 65536 (whole seconds per radian). cfg_ready is always high.
`include "goal_distance_turn_time_estimate_unit_assert.svh"

module goal_distance_turn_time_estimate_unit
	import gdte_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,

	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,

	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [POS_W-1:0] origin_x,
	input  logic signed [POS_W-1:0] origin_y,
	input  logic signed [HD_W-1:0]  origin_heading,
	input  logic signed [POS_W-1:0] goal_x,
	input  logic signed [POS_W-1:0] goal_y,

	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [31:0]             range_to_goal,
	output logic [31:0]             travel_secs,
	output logic signed [POS_W-1:0] est_x,
	output logic signed [POS_W-1:0] est_y,
	output logic signed [HD_W-1:0]  est_heading
);

	logic [CFG_W-1:0] spm_q, spr_q;

	logic signed [POS_W:0] dx, dy, ndx, ndy;
	cordic_t front;
	cordic_t front_s1;
	pass_t   pass_s1;
	logic    v_s1;
	logic    ld_s1;

	cordic_t cd  [CORDIC_STAGES+1];
	pass_t   ps  [CORDIC_STAGES+1];
	logic    vld [CORDIC_STAGES+1];
	logic    rdy [CORDIC_STAGES+1];
	pass_t   out_pass;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spm_q <= SPM_RESET;
			spr_q <= SPR_RESET;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_SECS_PER_METRE:  spm_q <= cfg_data;
				REG_SECS_PER_RADIAN: spr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// left half plane: pre-rotate by pi (or -pi below the axis)
	always_comb begin
		dx  = (POS_W + 1)'(goal_x) - (POS_W + 1)'(origin_x);
		dy  = (POS_W + 1)'(goal_y) - (POS_W + 1)'(origin_y);
		ndx = (POS_W + 1)'(origin_x) - (POS_W + 1)'(goal_x);
		ndy = (POS_W + 1)'(origin_y) - (POS_W + 1)'(goal_y);
		if (dx[POS_W]) begin
			front.x = XW'(ndx) <<< GUARD;
			front.y = XW'(ndy) <<< GUARD;
			front.z = dy[POS_W] ? -ANG_PI : ANG_PI;
		end else begin
			front.x = XW'(dx) <<< GUARD;
			front.y = XW'(dy) <<< GUARD;
			front.z = '0;
		end
	end

	assign ld_s1    = !v_s1 || rdy[0];
	assign in_ready = ld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ld_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1 && in_valid) begin
			front_s1        <= front;
			pass_s1.goal_x  <= goal_x;
			pass_s1.goal_y  <= goal_y;
			pass_s1.heading <= origin_heading;
		end
	end

	assign cd[0]  = front_s1;
	assign ps[0]  = pass_s1;
	assign vld[0] = v_s1;

	for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_rot
		gdte_cordic_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.idx       (IDX_W'(k)),
			.in_valid  (vld[k]),
			.in_ready  (rdy[k]),
			.in_vec    (cd[k]),
			.in_pass   (ps[k]),
			.out_valid (vld[k+1]),
			.out_ready (rdy[k+1]),
			.out_vec   (cd[k+1]),
			.out_pass  (ps[k+1])
		);
	end

	gdte_post u_post (
		.clk             (clk),
		.arst_n          (arst_n),
		.secs_per_metre  (spm_q),
		.secs_per_radian (spr_q),
		.in_valid        (vld[CORDIC_STAGES]),
		.in_ready        (rdy[CORDIC_STAGES]),
		.in_vec          (cd[CORDIC_STAGES]),
		.in_pass         (ps[CORDIC_STAGES]),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.range_to_goal   (range_to_goal),
		.travel_secs     (travel_secs),
		.out_pass        (out_pass)
	);

	assign est_x       = out_pass.goal_x;
	assign est_y       = out_pass.goal_y;
	assign est_heading = out_pass.heading;

	`GDTE_ASSERT_SAME(a_ready_when_empty, !v_s1, in_ready, "front stage empty but input not ready")
	`GDTE_ASSERT_SAME(a_right_half_plane, v_s1, !front_s1.x[XW-1], "pre-rotated x is negative")
	`GDTE_ASSERT_NEXT(a_beat_loaded, in_valid && in_ready, v_s1, "accepted beat not in front stage")
	`GDTE_ASSERT_NEXT(a_front_holds, v_s1 && !rdy[0], v_s1 && $stable(front_s1), "stalled front stage changed")

endmodule
